// ===== rtl/bwt_pkg.sv =====
// Shared types and constants for the breakpoint and watchpoint trigger table.
// Holds field widths, operation and status codes, table entry layouts and the
// sequencer state type. Depends on nothing.
`timescale 1ns / 1ps

package bwt_pkg;

   localparam int MODE_W   = 3;
   localparam int NODE_W   = 12;
   localparam int ADDR_W   = 18;
   localparam int VALUE_W  = 18;
   localparam int IDX_W    = 4;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   localparam int DEF_BREAK_SLOTS = 16;
   localparam int DEF_WATCH_SLOTS = 16;

   // A stored node of all ones matches any requesting node.
   localparam logic [NODE_W-1:0] ANY_NODE = 12'hFFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD_BREAK   = 3'd0,
      MODE_DEL_BREAK   = 3'd1,
      MODE_CHECK_FETCH = 3'd2,
      MODE_ADD_WATCH   = 3'd3,
      MODE_DEL_WATCH   = 3'd4,
      MODE_CHECK_WRITE = 3'd5,
      MODE_CHECK_READ  = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [ADDR_W-1:0] addr;
   } break_entry_type;

   typedef struct packed {
      logic [NODE_W-1:0]  node;
      logic [ADDR_W-1:0]  addr;
      logic               write_en;
      logic               read_en;
      logic [VALUE_W-1:0] prior_value;
   } watch_entry_type;

   function automatic logic node_hit(input logic [NODE_W-1:0] stored,
                                     input logic [NODE_W-1:0] node);
      return (stored == ANY_NODE) || (stored == node);
   endfunction

endpackage

// ===== rtl/bwt_req_if.sv =====
// Request channel of the trigger table: valid/ready handshake plus the
// operation fields of one transaction. Depends on bwt_pkg.
`timescale 1ns / 1ps

interface bwt_req_if;
   import bwt_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [NODE_W-1:0]  node_ident;
   logic [ADDR_W-1:0]  address;
   logic [VALUE_W-1:0] write_value;
   logic               trigger_on_write;
   logic               trigger_on_read;
   logic [IDX_W-1:0]   entry_index;

   modport source (
      output valid, mode, node_ident, address, write_value,
             trigger_on_write, trigger_on_read, entry_index,
      input  ready
   );

   modport sink (
      input  valid, mode, node_ident, address, write_value,
             trigger_on_write, trigger_on_read, entry_index,
      output ready
   );

endinterface

// ===== rtl/bwt_rsp_if.sv =====
// Response channel of the trigger table: valid/ready handshake plus the
// result fields of one transaction. Depends on bwt_pkg.
`timescale 1ns / 1ps

interface bwt_rsp_if;
   import bwt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_used;
   logic                pause_request;

   modport source (
      output valid, status, slot_used, pause_request,
      input  ready
   );

   modport sink (
      input  valid, status, slot_used, pause_request,
      output ready
   );

endinterface

// ===== rtl/bwt_ram.sv =====
// Single-port-write, single-port-read table storage with registered read data.
// Used for both the breakpoint and the watchpoint tables. Depends on bwt_pkg.
`timescale 1ns / 1ps

module bwt_ram #(
   parameter int DEPTH  = bwt_pkg::DEF_BREAK_SLOTS,
   parameter int WIDTH  = $bits(bwt_pkg::break_entry_type),
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/breakpoint_watchpoint_trigger_table_top.sv =====
// Breakpoint and watchpoint trigger table: sequencer, shared comparator and
// two table memories. Depends on bwt_pkg, bwt_req_if, bwt_rsp_if and bwt_ram.
//
// Usage:
//   The req channel carries one operation per transaction: add, delete or
//   check against the breakpoint table, or add, delete, write check or read
//   check against the watchpoint table. The rsp channel returns exactly one
//   transaction per request with status, slot_used and pause_request.
//   Adds, rejected deletes and unknown modes go from idle straight to the
//   done state and answer from there. Checks and deletes walk the table one
//   entry per cycle through the shared compare unit and the table's single
//   read port, then pass through the done state to the response register.
//   The walk covers every entry for a check and the entries above the index
//   for a delete. req.ready rises in the same cycle as the response becomes
//   valid, so the next request can be taken while that response waits.
//   One request is in progress at a time; req.ready is high only while the
//   sequencer is idle. The response sits in an output register, so a new
//   request may be taken while the previous response waits; if rsp.ready is
//   held low, the following result waits in the sequencer until the register
//   frees up. Reset empties both tables at once; no clearing pass is needed
//   because only entries below each table's count are ever read.
`timescale 1ns / 1ps

module breakpoint_watchpoint_trigger_table_top #(
   parameter int BREAK_SLOTS = bwt_pkg::DEF_BREAK_SLOTS,
   parameter int WATCH_SLOTS = bwt_pkg::DEF_WATCH_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   bwt_req_if.sink   req,
   bwt_rsp_if.source rsp
);
   import bwt_pkg::*;

   localparam int BAW   = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
   localparam int WAW   = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
   localparam int BCW   = $clog2(BREAK_SLOTS + 1);
   localparam int WCW   = $clog2(WATCH_SLOTS + 1);
   localparam int PTR_W = (BCW > WCW) ? BCW : WCW;
   localparam int EXT_W = (PTR_W > IDX_W) ? PTR_W : IDX_W;
   localparam int BEW   = $bits(break_entry_type);
   localparam int WEW   = $bits(watch_entry_type);

   // Sequencer and operand registers
   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   end_ff, end_in;
   logic [PTR_W-1:0]   cmp_ptr_ff, cmp_ptr_in;
   logic               issue_ff, issue_in;
   logic               pause_ff, pause_in;
   status_type         res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [BCW-1:0]     break_count_ff, break_count_in;
   logic [WCW-1:0]     watch_count_ff, watch_count_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_pause_ff, rsp_pause_in;

   // Memory ports
   logic               brk_wr_en, brk_rd_en;
   logic [BAW-1:0]     brk_wr_addr;
   break_entry_type    brk_wr_data, brk_q;
   logic [BEW-1:0]     brk_rd_data;
   logic               wch_wr_en, wch_rd_en;
   logic [WAW-1:0]     wch_wr_addr;
   watch_entry_type    wch_wr_data, wch_q;
   logic [WEW-1:0]     wch_rd_data;

   logic               accept;
   logic               walk_issue;
   logic               watch_op;
   logic [EXT_W-1:0]   idx_ext, idx_plus, bcnt_ext, wcnt_ext;
   logic [NODE_W-1:0]  entry_node;
   logic [ADDR_W-1:0]  entry_addr;
   logic               hit_base;
   logic               write_hit;
   logic               read_hit;

   bwt_ram #(
      .DEPTH (BREAK_SLOTS),
      .WIDTH (BEW),
      .ADDR_W(BAW)
   ) u_break_ram (
      .clock  (clock),
      .wr_en  (brk_wr_en),
      .wr_addr(brk_wr_addr),
      .wr_data(brk_wr_data),
      .rd_en  (brk_rd_en),
      .rd_addr(rd_ptr_ff[BAW-1:0]),
      .rd_data(brk_rd_data)
   );

   bwt_ram #(
      .DEPTH (WATCH_SLOTS),
      .WIDTH (WEW),
      .ADDR_W(WAW)
   ) u_watch_ram (
      .clock  (clock),
      .wr_en  (wch_wr_en),
      .wr_addr(wch_wr_addr),
      .wr_data(wch_wr_data),
      .rd_en  (wch_rd_en),
      .rd_addr(rd_ptr_ff[WAW-1:0]),
      .rd_data(wch_rd_data)
   );

   assign brk_q = break_entry_type'(brk_rd_data);
   assign wch_q = watch_entry_type'(wch_rd_data);

   assign req.ready         = (state_ff == ST_IDLE);
   assign accept            = req.valid && req.ready;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.slot_used     = rsp_slot_ff;
   assign rsp.pause_request = rsp_pause_ff;

   assign idx_ext  = EXT_W'(req.entry_index);
   assign idx_plus = idx_ext + EXT_W'(1);
   assign bcnt_ext = EXT_W'(break_count_ff);
   assign wcnt_ext = EXT_W'(watch_count_ff);

   assign watch_op = (mode_ff == MODE_DEL_WATCH) || (mode_ff == MODE_CHECK_WRITE) ||
                     (mode_ff == MODE_CHECK_READ);
   assign walk_issue = (state_ff == ST_WALK) && (rd_ptr_ff != end_ff);

   // Shared compare unit: one table entry per cycle from whichever memory
   // the current operation walks.
   assign entry_node = watch_op ? wch_q.node : brk_q.node;
   assign entry_addr = watch_op ? wch_q.addr : brk_q.addr;
   assign hit_base   = (entry_addr == addr_ff) && node_hit(entry_node, node_ff);
   assign write_hit  = wch_q.write_en && hit_base && (wch_q.prior_value != value_ff);
   assign read_hit   = wch_q.read_en && hit_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         issue_ff       <= 1'b0;
         break_count_ff <= '0;
         watch_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_ff       <= issue_in;
         break_count_ff <= break_count_in;
         watch_count_ff <= watch_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      node_ff       <= node_in;
      addr_ff       <= addr_in;
      value_ff      <= value_in;
      rd_ptr_ff     <= rd_ptr_in;
      end_ff        <= end_in;
      cmp_ptr_ff    <= cmp_ptr_in;
      pause_ff      <= pause_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pause_ff  <= rsp_pause_in;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      node_in        = node_ff;
      addr_in        = addr_ff;
      value_in       = value_ff;
      rd_ptr_in      = rd_ptr_ff;
      end_in         = end_ff;
      cmp_ptr_in     = cmp_ptr_ff;
      issue_in       = 1'b0;
      pause_in       = pause_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      break_count_in = break_count_ff;
      watch_count_in = watch_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_pause_in   = rsp_pause_ff;

      brk_wr_en   = 1'b0;
      brk_wr_addr = cmp_ptr_ff[BAW-1:0];
      brk_wr_data = brk_q;
      brk_rd_en   = 1'b0;
      wch_wr_en   = 1'b0;
      wch_wr_addr = cmp_ptr_ff[WAW-1:0];
      wch_wr_data = wch_q;
      wch_rd_en   = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in       = req.mode;
               node_in       = req.node_ident;
               addr_in       = req.address;
               value_in      = req.write_value;
               pause_in      = 1'b0;
               res_status_in = STATUS_OK;
               res_slot_in   = '0;
               state_in      = ST_DONE;
               case (mode_type'(req.mode))
                  MODE_ADD_BREAK: begin
                     if (break_count_ff == BCW'(BREAK_SLOTS)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        brk_wr_en        = 1'b1;
                        brk_wr_addr      = break_count_ff[BAW-1:0];
                        brk_wr_data.node = req.node_ident;
                        brk_wr_data.addr = req.address;
                        res_slot_in      = SLOT_W'(break_count_ff);
                        break_count_in   = break_count_ff + BCW'(1);
                     end
                  end
                  MODE_ADD_WATCH: begin
                     if (watch_count_ff == WCW'(WATCH_SLOTS)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        wch_wr_en               = 1'b1;
                        wch_wr_addr             = watch_count_ff[WAW-1:0];
                        wch_wr_data.node        = req.node_ident;
                        wch_wr_data.addr        = req.address;
                        wch_wr_data.write_en    = req.trigger_on_write;
                        wch_wr_data.read_en     = req.trigger_on_read;
                        wch_wr_data.prior_value = '0;
                        res_slot_in             = SLOT_W'(watch_count_ff);
                        watch_count_in          = watch_count_ff + WCW'(1);
                     end
                  end
                  MODE_DEL_BREAK: begin
                     if (idx_ext >= bcnt_ext) begin
                        res_status_in = STATUS_BAD_INDEX;
                     end else begin
                        // Later entries move down one slot.
                        rd_ptr_in = idx_plus[PTR_W-1:0];
                        end_in    = PTR_W'(break_count_ff);
                        state_in  = ST_WALK;
                     end
                  end
                  MODE_DEL_WATCH: begin
                     if (idx_ext >= wcnt_ext) begin
                        res_status_in = STATUS_BAD_INDEX;
                     end else begin
                        rd_ptr_in = idx_plus[PTR_W-1:0];
                        end_in    = PTR_W'(watch_count_ff);
                        state_in  = ST_WALK;
                     end
                  end
                  MODE_CHECK_FETCH: begin
                     rd_ptr_in = '0;
                     end_in    = PTR_W'(break_count_ff);
                     state_in  = ST_WALK;
                  end
                  MODE_CHECK_WRITE, MODE_CHECK_READ: begin
                     rd_ptr_in = '0;
                     end_in    = PTR_W'(watch_count_ff);
                     state_in  = ST_WALK;
                  end
                  default: begin
                     // Unused mode: answer with all fields zero.
                  end
               endcase
            end
         end

         ST_WALK: begin
            // Read one entry per cycle; its data is compared or moved in the
            // following cycle, while the next entry is being read.
            if (walk_issue) begin
               issue_in  = 1'b1;
               rd_ptr_in = rd_ptr_ff + PTR_W'(1);
               brk_rd_en = !watch_op;
               wch_rd_en = watch_op;
               if ((mode_ff == MODE_DEL_BREAK) || (mode_ff == MODE_DEL_WATCH)) begin
                  cmp_ptr_in = rd_ptr_ff - PTR_W'(1);
               end else begin
                  cmp_ptr_in = rd_ptr_ff;
               end
            end

            if (issue_ff) begin
               case (mode_type'(mode_ff))
                  MODE_DEL_BREAK: begin
                     brk_wr_en = 1'b1;
                  end
                  MODE_DEL_WATCH: begin
                     wch_wr_en = 1'b1;
                  end
                  MODE_CHECK_FETCH: begin
                     pause_in = pause_ff || hit_base;
                  end
                  MODE_CHECK_WRITE: begin
                     if (write_hit) begin
                        wch_wr_en               = 1'b1;
                        wch_wr_data.prior_value = value_ff;
                        pause_in                = 1'b1;
                     end
                  end
                  MODE_CHECK_READ: begin
                     pause_in = pause_ff || read_hit;
                  end
                  default: begin
                  end
               endcase
            end

            if (!walk_issue) begin
               state_in = ST_DONE;
               if (mode_ff == MODE_DEL_BREAK) begin
                  break_count_in = break_count_ff - BCW'(1);
               end else if (mode_ff == MODE_DEL_WATCH) begin
                  watch_count_in = watch_count_ff - WCW'(1);
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_pause_in  = pause_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bwt_checker.sv =====
// Port-level checks for the trigger table top level, attached by a bind.
// Depends on bwt_pkg and breakpoint_watchpoint_trigger_table_top.
`timescale 1ns / 1ps

module bwt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bwt_pkg::STATUS_W-1:0]  rsp_status,
   input logic [bwt_pkg::SLOT_W-1:0]    rsp_slot_used,
   input logic                          rsp_pause_request
);
   import bwt_pkg::*;

   // Only one operation is in progress at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an operation was in progress");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");

   // A rejected add or delete carries no slot and no trigger.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         ((rsp_slot_used == '0) && !rsp_pause_request))
      else $error("error response carries slot or trigger");

   // A trigger only comes from a check, which never reports a slot or error.
   a_trigger_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pause_request) |->
         ((rsp_status == STATUS_OK) && (rsp_slot_used == '0)))
      else $error("trigger response carries slot or error");

endmodule

bind breakpoint_watchpoint_trigger_table_top bwt_checker u_bwt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_slot_used    (rsp.slot_used),
   .rsp_pause_request(rsp.pause_request)
);
